// ===== rtl/gcne_pkg.sv =====
// Package for the grid cell neighbor enumerator.
// Holds grid size, field widths, register indexes and the per-axis cell math.
// No dependencies.
package gcne_pkg;

	localparam int CELLS_PER_AXIS = 16;
	localparam int COORD_W = (CELLS_PER_AXIS > 2) ? $clog2(CELLS_PER_AXIS) : 1;
	localparam int CELL_W = 12;

	localparam int POS_W = 16;
	localparam int RADIUS_W = 15;
	localparam int SCALE_W = 16;
	localparam int SUM_W = 18;
	localparam int PROD_W = 35;
	localparam int FRAC_W = 16;
	localparam int CELLQ_W = PROD_W - FRAC_W;
	localparam int IDX_W = (3 * COORD_W + 2 > CELL_W) ? 3 * COORD_W + 2 : CELL_W;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	typedef enum logic [0:0] {
		REG_BOUND_RADIUS   = 1'b0,
		REG_CELLS_PER_UNIT = 1'b1
	} reg_idx_t;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [CELL_W-1:0] cell_t;
	typedef logic signed [1:0] step_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	localparam coord_t COORD_MAX = coord_t'(CELLS_PER_AXIS - 1);
	localparam step_t STEP_NEG = -2'sd1;
	localparam step_t STEP_ZERO = 2'sd0;
	localparam step_t STEP_POS = 2'sd1;

	// Truncate the Q.16 product and clamp to the grid.
	function automatic coord_t axis_cell(prod_t prod);
		logic [CELLQ_W-1:0] q;
		q = prod[PROD_W-1:FRAC_W];
		if (prod <= 0)
			return '0;
		else if (q > CELLQ_W'(CELLS_PER_AXIS - 1))
			return COORD_MAX;
		else
			return q[COORD_W-1:0];
	endfunction

	// Linear cell index, kept to the low CELL_W bits.
	function automatic cell_t lin_index(coord_t x, coord_t y, coord_t z);
		logic [IDX_W-1:0] v;
		v = IDX_W'(x) + IDX_W'(y) * IDX_W'(CELLS_PER_AXIS)
			+ IDX_W'(z) * IDX_W'(CELLS_PER_AXIS * CELLS_PER_AXIS);
		return v[CELL_W-1:0];
	endfunction

	function automatic coord_t step_coord(coord_t c, step_t d);
		logic signed [COORD_W:0] s;
		s = $signed({1'b0, c}) + (COORD_W + 1)'(d);
		return s[COORD_W-1:0];
	endfunction

endpackage

// ===== rtl/gcne_in_if.sv =====
// Position channel of the grid cell neighbor enumerator.
// Depends on gcne_pkg.
interface gcne_in_if import gcne_pkg::*;;
	logic valid;
	logic ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;

	modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// ===== rtl/gcne_out_if.sv =====
// Neighbor cell channel of the grid cell neighbor enumerator.
// Depends on gcne_pkg.
interface gcne_out_if import gcne_pkg::*;;
	logic valid;
	logic ready;
	cell_t home_cell;
	cell_t neighbor_cell;
	step_t step_x;
	step_t step_y;
	step_t step_z;
	logic last;

	modport source (output valid, output home_cell, output neighbor_cell,
		output step_x, output step_y, output step_z, output last, input ready);
	modport sink (input valid, input home_cell, input neighbor_cell,
		input step_x, input step_y, input step_z, input last, output ready);
endinterface

// ===== rtl/grid_cell_neighbor_enumerator.sv =====
// Channel     Dir  Item
// pos_in      in   pos_x, pos_y, pos_z (signed Q7.8)
// cell_out    out  home_cell, neighbor_cell, step_x/y/z, last
// apb         in   bound_radius (0x0), cells_per_unit (0x4)
//
// An item passes through the add stage and the multiply stage, then the
// enumerator emits one neighbor per cycle while the output is not stalled:
// 8 to 27 neighbors per item, set by the count of in-grid neighbors. The first
// result leaves through the output register behind the enumerator.
// The next item waits in the pipeline and loads at the edge the last neighbor
// leaves. A stalled output holds every stage behind it. Reset loads the
// register defaults and empties all stages.
// Depends on gcne_pkg, gcne_in_if, gcne_out_if.
module grid_cell_neighbor_enumerator import gcne_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	gcne_in_if.sink           pos_in,
	gcne_out_if.source        cell_out
);

	logic [RADIUS_W-1:0] radius_q;
	logic [SCALE_W-1:0] scale_q;

	logic v_s1;
	sum_t sum_s1 [3];
	logic v_s2;
	prod_t prod_s2 [3];

	logic busy_q;
	coord_t c_q [3];
	step_t d_q [3];
	cell_t home_q;

	logic out_valid_q;
	cell_t out_home_q;
	cell_t out_nbr_q;
	step_t out_step_q [3];
	logic out_last_q;

	logic out_free, enum_step, enum_done, enum_free, s2_free, s1_free;
	logic last_now;
	logic d_end [3];
	step_t d_first [3];
	step_t d_next [3];
	coord_t n_c [3];
	coord_t ld_c [3];
	step_t ld_first [3];
	prod_t prod [3];
	sum_t sum [3];
	logic signed [POS_W-1:0] pos [3];

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_W'(256);
			scale_q <= SCALE_W'(2048);
		end else if (psel && penable && pwrite) begin
			case (reg_idx_t'(paddr[2]))
				REG_BOUND_RADIUS: radius_q <= pwdata[RADIUS_W-1:0];
				REG_CELLS_PER_UNIT: scale_q <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_BOUND_RADIUS: prdata = DATA_W'(radius_q);
			REG_CELLS_PER_UNIT: prdata = DATA_W'(scale_q);
			default: prdata = '0;
		endcase
	end

	// flow control
	assign out_free = !out_valid_q || cell_out.ready;
	assign enum_step = busy_q && out_free;
	assign enum_done = enum_step && last_now;
	assign enum_free = !busy_q || enum_done;
	assign s2_free = !v_s2 || enum_free;
	assign s1_free = !v_s1 || s2_free;
	assign pos_in.ready = s1_free;

	assign pos[0] = pos_in.pos_x;
	assign pos[1] = pos_in.pos_y;
	assign pos[2] = pos_in.pos_z;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sum[a] = sum_t'(pos[a]) + sum_t'(radius_q);
			prod[a] = sum_s1[a] * $signed({1'b0, scale_q});
			ld_c[a] = axis_cell(prod_s2[a]);
			ld_first[a] = (ld_c[a] == '0) ? STEP_ZERO : STEP_NEG;
			d_first[a] = (c_q[a] == '0) ? STEP_ZERO : STEP_NEG;
			d_end[a] = (d_q[a] == ((c_q[a] == COORD_MAX) ? STEP_ZERO : STEP_POS));
			n_c[a] = step_coord(c_q[a], d_q[a]);
		end
		last_now = d_end[0] && d_end[1] && d_end[2];
		// x runs fastest, then y, then z
		d_next[0] = d_end[0] ? d_first[0] : d_q[0] + STEP_POS;
		d_next[1] = d_q[1];
		d_next[2] = d_q[2];
		if (d_end[0]) begin
			d_next[1] = d_end[1] ? d_first[1] : d_q[1] + STEP_POS;
			if (d_end[1] && !d_end[2])
				d_next[2] = d_q[2] + STEP_POS;
		end
	end

	// add and multiply stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_free)
				v_s1 <= pos_in.valid;
			if (s2_free)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && pos_in.valid)
			sum_s1 <= sum;
		if (s2_free && v_s1)
			prod_s2 <= prod;
	end

	// enumerator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (enum_free)
			busy_q <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (enum_free && v_s2) begin
			c_q <= ld_c;
			d_q <= ld_first;
			home_q <= lin_index(ld_c[0], ld_c[1], ld_c[2]);
		end else if (enum_step) begin
			d_q <= d_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= busy_q;
	end

	always_ff @(posedge clk) begin
		if (enum_step) begin
			out_home_q <= home_q;
			out_nbr_q <= lin_index(n_c[0], n_c[1], n_c[2]);
			out_step_q <= d_q;
			out_last_q <= last_now;
		end
	end

	assign cell_out.valid = out_valid_q;
	assign cell_out.home_cell = out_home_q;
	assign cell_out.neighbor_cell = out_nbr_q;
	assign cell_out.step_x = out_step_q[0];
	assign cell_out.step_y = out_step_q[1];
	assign cell_out.step_z = out_step_q[2];
	assign cell_out.last = out_last_q;

`ifndef SYNTHESIS
	a_step_code: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (d_q[0] != 2'sb10 && d_q[1] != 2'sb10 && d_q[2] != 2'sb10))
		else $error("enumerator offset out of range");

	a_stay_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (!(c_q[0] == '0 && d_q[0] == STEP_NEG)
			&& !(c_q[0] == COORD_MAX && d_q[0] == STEP_POS)))
		else $error("neighbor x outside the grid");

	a_no_load_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && enum_free) |=> busy_q)
		else $error("item dropped between multiply stage and enumerator");

	a_last_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_out.valid && cell_out.last) |-> (cell_out.step_x != STEP_NEG
			&& cell_out.step_y != STEP_NEG && cell_out.step_z != STEP_NEG))
		else $error("last item carries a negative offset");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for grid_cell_neighbor_enumerator: directed and random positions
// and register settings, with each neighbor item checked against a built-in grid predictor.
// Depends on gcne_pkg, gcne_in_if, gcne_out_if and the block itself.
`timescale 1ns / 1ps

module testbench;
	import gcne_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_AFTER = 600;
	localparam int HOLD_LENGTH = 300;
	localparam int PHASE_ITEMS = 47;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] z;
	} position_t;

	typedef struct {
		cell_t home;
		cell_t nbr;
		step_t sx;
		step_t sy;
		step_t sz;
		logic last;
	} neighbor_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	gcne_in_if pos_if();
	gcne_out_if cell_if();

	grid_cell_neighbor_enumerator uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.pos_in(pos_if),
		.cell_out(cell_if)
	);

	// shadow copy of the block's registers
	logic [RADIUS_W-1:0] cfg_radius = RADIUS_W'(256);
	logic [SCALE_W-1:0] cfg_scale = SCALE_W'(2048);

	position_t pos_queue[$];
	neighbor_t expected_cells[$];
	int items_queued = 0;
	int items_accepted = 0;
	int cells_checked = 0;
	int fail_count = 0;
	int cycle_count = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_cycles = 0;
	bit hold_done = 1'b0;
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	bit offering;

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("grid_cell_neighbor_enumerator test failed");
			$finish;
		end
	end

	// Truncate the scaled coordinate toward zero and clamp it to the grid.
	function automatic int grid_coord(logic signed [POS_W-1:0] p);
		longint acc;
		acc = (longint'(p) + longint'(cfg_radius)) * longint'(cfg_scale);
		if (acc <= 0)
			return 0;
		acc = acc >>> FRAC_W;
		return (acc > CELLS_PER_AXIS - 1) ? CELLS_PER_AXIS - 1 : int'(acc);
	endfunction

	function automatic cell_t flat_cell(int x, int y, int z);
		return cell_t'(x + y * CELLS_PER_AXIS + z * CELLS_PER_AXIS * CELLS_PER_AXIS);
	endfunction

	task automatic predict_neighbors(position_t p);
		int cx, cy, cz, first;
		neighbor_t rec;
		cx = grid_coord($signed(p.x));
		cy = grid_coord($signed(p.y));
		cz = grid_coord($signed(p.z));
		first = expected_cells.size();
		for (int dz = -1; dz <= 1; dz++) begin
			for (int dy = -1; dy <= 1; dy++) begin
				for (int dx = -1; dx <= 1; dx++) begin
					if (cz + dz < 0 || cz + dz > CELLS_PER_AXIS - 1 ||
						cy + dy < 0 || cy + dy > CELLS_PER_AXIS - 1 ||
						cx + dx < 0 || cx + dx > CELLS_PER_AXIS - 1)
						continue;
					rec.home = flat_cell(cx, cy, cz);
					rec.nbr = flat_cell(cx + dx, cy + dy, cz + dz);
					rec.sx = step_t'(dx);
					rec.sy = step_t'(dy);
					rec.sz = step_t'(dz);
					rec.last = 1'b0;
					expected_cells.insert(expected_cells.size(), rec);
				end
			end
		end
		// mark the final neighbor of this position
		if (expected_cells.size() > first)
			expected_cells[expected_cells.size() - 1].last = 1'b1;
	endtask

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	task automatic check_neighbor();
		neighbor_t want;
		if (expected_cells.size() == 0) begin
			note_failure($sformatf("unexpected item: home %0d nbr %0d step %0d/%0d/%0d last %0b",
				cell_if.home_cell, cell_if.neighbor_cell, cell_if.step_x, cell_if.step_y,
				cell_if.step_z, cell_if.last));
			return;
		end
		want = expected_cells.pop_front();
		cells_checked++;
		if (cell_if.home_cell !== want.home || cell_if.neighbor_cell !== want.nbr ||
			cell_if.step_x !== want.sx || cell_if.step_y !== want.sy ||
			cell_if.step_z !== want.sz || cell_if.last !== want.last)
			note_failure($sformatf({"mismatch: exp home %0d nbr %0d step %0d/%0d/%0d last %0b,",
				" got home %0d nbr %0d step %0d/%0d/%0d last %0b"},
				want.home, want.nbr, want.sx, want.sy, want.sz, want.last,
				cell_if.home_cell, cell_if.neighbor_cell, cell_if.step_x, cell_if.step_y,
				cell_if.step_z, cell_if.last));
	endtask

	// position driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_if.valid <= 1'b0;
			pos_if.pos_x <= '0;
			pos_if.pos_y <= '0;
			pos_if.pos_z <= '0;
			send_gap = 0;
		end else begin
			offering = pos_if.valid;
			if (pos_if.valid && pos_if.ready) begin
				predict_neighbors('{pos_if.pos_x, pos_if.pos_y, pos_if.pos_z});
				items_accepted++;
				offering = 1'b0;
				send_gap = send_idle ? $urandom_range(0, 11) : 0;
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
					pos_if.valid <= 1'b0;
				end else if (pos_queue.size() > 0) begin
					pos_if.valid <= 1'b1;
					pos_if.pos_x <= pos_queue[0].x;
					pos_if.pos_y <= pos_queue[0].y;
					pos_if.pos_z <= pos_queue[0].z;
					void'(pos_queue.pop_front());
				end else begin
					pos_if.valid <= 1'b0;
				end
			end
		end
	end

	// neighbor monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_if.ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (cell_if.valid && cell_if.ready) begin
				check_neighbor();
				recv_gap = recv_idle ? $urandom_range(0, 11) : 0;
			end
			if (hold_cycles != 0 || recv_gap != 0) begin
				cell_if.ready <= 1'b0;
				if (recv_gap != 0)
					recv_gap--;
			end else begin
				cell_if.ready <= 1'b1;
			end
		end
	end

	// one long receiver hold-off so the pipeline backs up into the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && cells_checked >= HOLD_AFTER) begin
			hold_cycles <= HOLD_LENGTH;
			hold_done <= 1'b1;
		end else if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	task automatic queue_position(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
		logic [POS_W-1:0] z);
		pos_queue.insert(pos_queue.size(), position_t'{x, y, z});
		items_queued++;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_BOUND_RADIUS: cfg_radius = value[RADIUS_W-1:0];
			REG_CELLS_PER_UNIT: cfg_scale = value[SCALE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (items_accepted != items_queued || expected_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly positions inside the cube, some anywhere, some near its faces.
	function automatic logic [POS_W-1:0] random_position(int r);
		int v;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			v = int'($urandom_range(0, 2 * r)) - r;
		else if (pick < 8)
			v = int'($urandom_range(0, 65535)) - 32768;
		else
			v = ($urandom_range(0, 1) ? r : -r) + int'($urandom_range(0, 80)) - 40;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[POS_W-1:0];
	endfunction

	function automatic int fitted_scale(int r);
		int s;
		s = (r == 0) ? 65535 : 524288 / r;
		return (s > 65535) ? 65535 : s;
	endfunction

	initial begin
		int r;
		int s;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: cell = (pos + 256) / 32
		queue_position(0, 0, 0);
		queue_position(-256, -256, -256);
		queue_position(255, 255, 255);
		queue_position(-32768, -32768, -32768);
		queue_position(32767, 32767, 32767);
		queue_position(-32768, 32767, 0);
		queue_position(-1, -1, -1);
		queue_position(-225, 0, 0);
		queue_position(-224, 0, 0);
		queue_position(223, 223, 0);
		queue_position(224, 0, 0);
		queue_position(-257, 0, 0);
		queue_position(0, -256, 255);
		queue_position(100, -300, 32767);
		queue_position(16'h5555, 16'hAAAA, 0);
		wait_drained();

		// zero scale lands everything in cell 0
		write_reg(REG_CELLS_PER_UNIT, 0);
		queue_position(0, 0, 0);
		queue_position(32767, -32768, 100);
		wait_drained();

		write_reg(REG_BOUND_RADIUS, 0);
		write_reg(REG_CELLS_PER_UNIT, 65535);
		queue_position(15, 16, -1);
		queue_position(32767, 1, 2);
		queue_position(0, 14, 15);
		wait_drained();

		write_reg(REG_BOUND_RADIUS, 32767);
		write_reg(REG_CELLS_PER_UNIT, 16);
		queue_position(0, 0, 0);
		queue_position(32767, -32768, 0);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin r = 256; s = 2048; end
				1: begin r = $urandom_range(64, 4096); s = fitted_scale(r); end
				2: begin r = 32767; s = 16; end
				3: begin r = $urandom_range(8, 64); s = fitted_scale(r); end
				4: begin r = $urandom_range(0, 32767); s = $urandom_range(0, 65535); end
				default: begin
					r = $urandom_range(1, 2000);
					s = fitted_scale(r) * int'($urandom_range(8, 12)) / 10;
					if (s > 65535)
						s = 65535;
				end
			endcase
			write_reg(REG_BOUND_RADIUS, r);
			write_reg(REG_CELLS_PER_UNIT, s);
			send_idle = (ph != 1 && ph != 3);
			recv_idle = (ph != 1 && ph != 2);
			for (int i = 0; i < PHASE_ITEMS; i++)
				queue_position(random_position(r), random_position(r), random_position(r));
			wait_drained();
		end

		if (fail_count == 0 && expected_cells.size() == 0) begin
			$display("grid_cell_neighbor_enumerator test passed");
		end else begin
			$display("grid_cell_neighbor_enumerator test failed");
		end
		$finish;
	end

endmodule
